>>> rtl/hlr_pkg.sv
`default_nettype none

package hlr_pkg;

  localparam int HopChannels = 30;

  localparam logic [7:0]        FrameHeader = 8'h81;
  localparam logic signed [7:0] HopLastS    = 8'(HopChannels - 1);
  localparam logic signed [7:0] HopWrapS    = 8'sd31;
  localparam int                HopTries    = 3;

  localparam logic [4:0]  HopChanReset  = 5'd2;
  localparam logic [19:0] HuntDwellRst  = 20'd500000;
  localparam logic [15:0] SyncEmptyRst  = 16'd6800;
  localparam logic [15:0] SyncLowRst    = 16'd3500;
  localparam logic [15:0] SyncHighRst   = 16'd500;
  localparam logic [7:0]  MaxMissedRst  = 8'd100;
  localparam logic [8:0]  MissedSat     = 9'd511;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTxidFirst  = 3'd0,
    CfgTxidSecond = 3'd1,
    CfgHuntDwell  = 3'd2,
    CfgSyncEmpty  = 3'd3,
    CfgSyncLow    = 3'd4,
    CfgSyncHigh   = 3'd5,
    CfgMaxMissed  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic        command;
    logic [31:0] now_us;
    logic [7:0]  header_byte;
    logic [7:0]  tx_first;
    logic [7:0]  tx_second;
    logic [63:0] body;
    logic [7:0]  rssi_byte;
    logic [7:0]  status_byte;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic        group;
    logic [11:0] chan_a;
    logic [11:0] chan_b;
    logic [11:0] chan_c;
    logic [11:0] chan_d;
    logic [4:0]  radio_channel;
    logic        retune;
    logic        linked;
    logic [7:0]  rssi;
    logic        rssi_valid;
  } out_item_t;

  // Fields pulled out of the frame body.
  typedef struct packed {
    logic [4:0]  chan_field;
    logic [4:0]  code;
    logic        group_hi;
    logic        failsafe;
    logic [11:0] val_a;
    logic [11:0] val_b;
    logic [11:0] val_c;
    logic [11:0] val_d;
  } frame_fields_t;

  // Advance the hop channel by code+2, wrap above the last channel,
  // retry while negative, fall back to zero if still negative.
  function automatic logic [4:0] hop_step(logic [4:0] ch, logic [4:0] code);
    logic signed [7:0] c;
    logic signed [7:0] st;
    logic              done;
    c    = {3'b000, ch};
    st   = {3'b000, code} + 8'sd2;
    done = 1'b0;
    for (int k = 0; k < HopTries; k++) begin
      if (!done) begin
        c = c + st;
        if (c > HopLastS) c = c - HopWrapS;
        if (c >= 8'sd0) done = 1'b1;
      end
    end
    if (c < 8'sd0) c = 8'sd0;
    return c[4:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/hlr_in_if.sv
`default_nettype none

interface hlr_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] now_us;
  logic [7:0]  header_byte;
  logic [7:0]  tx_first;
  logic [7:0]  tx_second;
  logic [63:0] body;
  logic [7:0]  rssi_byte;
  logic [7:0]  status_byte;

  modport source (
    output valid, command, now_us, header_byte, tx_first, tx_second, body,
           rssi_byte, status_byte,
    input  ready
  );
  modport sink (
    input  valid, command, now_us, header_byte, tx_first, tx_second, body,
           rssi_byte, status_byte,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/hlr_out_if.sv
`default_nettype none

interface hlr_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        group;
  logic [11:0] chan_a;
  logic [11:0] chan_b;
  logic [11:0] chan_c;
  logic [11:0] chan_d;
  logic [4:0]  radio_channel;
  logic        retune;
  logic        linked;
  logic [7:0]  rssi;
  logic        rssi_valid;

  modport source (
    output valid, status, group, chan_a, chan_b, chan_c, chan_d, radio_channel,
           retune, linked, rssi, rssi_valid,
    input  ready
  );
  modport sink (
    input  valid, status, group, chan_a, chan_b, chan_c, chan_d, radio_channel,
           retune, linked, rssi, rssi_valid,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/hlr_frame_dec.sv
`default_nettype none

// Slice the frame body into hop channel, hop code, flags and channel values.
module hlr_frame_dec (
  input  logic [63:0]                 body_i,
  output hlr_pkg::frame_fields_t      fields_o
);

  always_comb begin
    fields_o.chan_field = body_i[63:59];
    fields_o.code       = {body_i[10:8], body_i[7:6]};
    fields_o.group_hi   = body_i[3];
    fields_o.failsafe   = body_i[2];
    fields_o.val_a      = body_i[58:47];
    fields_o.val_b      = body_i[46:35];
    fields_o.val_c      = body_i[34:23];
    fields_o.val_d      = body_i[22:11];
  end

endmodule

`default_nettype wire

>>> rtl/hopping_link_receiver.sv
`default_nettype none

// Channel   Dir  Handshake      Payload
// in_i      in   valid/ready    command, now_us, header_byte, tx ids, body, rssi, status
// out_o     out  valid/ready    status, group, chan_a..d, radio_channel, retune, linked,
//                               rssi, rssi_valid
// cfg       in   cfg_we_i       cfg_idx_i selects the register, cfg_wdata_i carries it
//
// One item per cycle sustained while the output is not stalled.
// The poll is held in an input register, evaluated against the link state in one
// pass, and the result and new state are loaded in the same edge.
// Reset puts the link in hunt on hop channel 2 with the default timing registers.
// A stalled output holds its item; the input register keeps accepting as long as
// its item can move into the output register.

module hopping_link_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hlr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hlr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  hlr_in_if.sink                        in_i,
  hlr_out_if.source                     out_o
);

  // Configuration registers
  logic [7:0]  txid_first_q, txid_second_q, max_missed_q;
  logic [19:0] hunt_dwell_q;
  logic [15:0] sync_empty_q, sync_low_q, sync_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      txid_first_q  <= '0;
      txid_second_q <= '0;
      hunt_dwell_q  <= hlr_pkg::HuntDwellRst;
      sync_empty_q  <= hlr_pkg::SyncEmptyRst;
      sync_low_q    <= hlr_pkg::SyncLowRst;
      sync_high_q   <= hlr_pkg::SyncHighRst;
      max_missed_q  <= hlr_pkg::MaxMissedRst;
    end else if (cfg_we_i) begin
      unique case (hlr_pkg::cfg_idx_e'(cfg_idx_i))
        hlr_pkg::CfgTxidFirst:  txid_first_q  <= cfg_wdata_i[7:0];
        hlr_pkg::CfgTxidSecond: txid_second_q <= cfg_wdata_i[7:0];
        hlr_pkg::CfgHuntDwell:  hunt_dwell_q  <= cfg_wdata_i;
        hlr_pkg::CfgSyncEmpty:  sync_empty_q  <= cfg_wdata_i[15:0];
        hlr_pkg::CfgSyncLow:    sync_low_q    <= cfg_wdata_i[15:0];
        hlr_pkg::CfgSyncHigh:   sync_high_q   <= cfg_wdata_i[15:0];
        hlr_pkg::CfgMaxMissed:  max_missed_q  <= cfg_wdata_i[7:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Handshake: output register frees up when empty or taken this cycle
  logic out_vld_q;
  logic s1_vld_q;
  logic out_free;
  logic s1_fire;

  assign out_free    = !out_vld_q || out_o.ready;
  assign s1_fire     = s1_vld_q && out_free;
  assign in_i.ready  = !s1_vld_q || out_free;

  // Input register
  hlr_pkg::in_item_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q.command     <= in_i.command;
      s1_q.now_us      <= in_i.now_us;
      s1_q.header_byte <= in_i.header_byte;
      s1_q.tx_first    <= in_i.tx_first;
      s1_q.tx_second   <= in_i.tx_second;
      s1_q.body        <= in_i.body;
      s1_q.rssi_byte   <= in_i.rssi_byte;
      s1_q.status_byte <= in_i.status_byte;
    end
  end

  hlr_pkg::frame_fields_t fr;

  hlr_frame_dec u_dec (
    .body_i   (s1_q.body),
    .fields_o (fr)
  );

  // Link state
  logic        linked_q, linked_d;
  logic [4:0]  hop_q, hop_d;
  logic [4:0]  code_q, code_d;
  logic [31:0] deadline_q, deadline_d;
  logic [1:0]  groups_q, groups_d;
  logic [8:0]  missed_q, missed_d;
  logic [7:0]  rssi_q, rssi_d;

  hlr_pkg::out_item_t res_d, res_q;

  logic        frame_ok;
  logic        passed;
  logic [31:0] since;
  logic [4:0]  hop_next;
  logic [8:0]  missed_inc;

  assign since    = s1_q.now_us - deadline_q;
  // Deadline has passed when the signed difference is strictly positive
  assign passed   = (since != '0) && !since[31];
  assign hop_next = hlr_pkg::hop_step(hop_q, code_q);
  assign missed_inc = (missed_q == hlr_pkg::MissedSat) ? missed_q : missed_q + 9'd1;

  assign frame_ok = s1_q.command
                 && s1_q.status_byte[7]
                 && (s1_q.header_byte == hlr_pkg::FrameHeader)
                 && (fr.chan_field == hop_q)
                 && (s1_q.tx_first == txid_first_q)
                 && (s1_q.tx_second == txid_second_q);

  always_comb begin
    linked_d   = linked_q;
    hop_d      = hop_q;
    code_d     = code_q;
    deadline_d = deadline_q;
    groups_d   = groups_q;
    missed_d   = missed_q;
    rssi_d     = rssi_q;
    res_d      = '0;

    // A valid frame always refreshes code and signal strength
    if (frame_ok) begin
      rssi_d           = s1_q.rssi_byte;
      code_d           = fr.code;
      res_d.rssi_valid = 1'b1;
    end

    if (!linked_q) begin
      if (s1_q.command) begin
        // Only a group 5-8 frame locks the link
        if (frame_ok && fr.group_hi) begin
          missed_d   = '0;
          groups_d   = 2'b11;
          linked_d   = 1'b1;
          deadline_d = s1_q.now_us + {16'd0, sync_high_q};
        end
      end else if (passed) begin
        hop_d        = hop_next;
        res_d.retune = 1'b1;
        deadline_d   = deadline_q + {12'd0, hunt_dwell_q};
      end
    end else begin
      if (s1_q.command) begin
        if (frame_ok) begin
          missed_d = '0;
          if (fr.group_hi) begin
            deadline_d = s1_q.now_us + {16'd0, sync_high_q};
            groups_d   = groups_q | 2'b10;
          end else begin
            deadline_d = s1_q.now_us + {16'd0, sync_low_q};
            groups_d   = groups_q | 2'b01;
          end
          if (!fr.failsafe) begin
            res_d.status = 1'b1;
            res_d.group  = fr.group_hi;
            res_d.chan_a = fr.val_a;
            res_d.chan_b = fr.val_b;
            res_d.chan_c = fr.val_c;
            res_d.chan_d = fr.val_d;
          end
        end
      end else if (passed) begin
        deadline_d   = deadline_q + {16'd0, sync_empty_q};
        hop_d        = hop_next;
        res_d.retune = 1'b1;
        groups_d     = '0;
        // Empty window: count it, and fall back to hunt past the limit
        if (groups_q == 2'b00) begin
          missed_d = missed_inc;
          if (missed_inc > {1'b0, max_missed_q}) begin
            linked_d   = 1'b0;
            rssi_d     = '0;
            deadline_d = s1_q.now_us + {12'd0, hunt_dwell_q};
            groups_d   = groups_q;
          end
        end
      end
    end

    res_d.radio_channel = hop_d;
    res_d.linked        = linked_d;
    res_d.rssi          = rssi_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linked_q   <= 1'b0;
      hop_q      <= hlr_pkg::HopChanReset;
      code_q     <= '0;
      deadline_q <= 32'(hlr_pkg::HuntDwellRst);
      groups_q   <= '0;
      missed_q   <= '0;
      rssi_q     <= '0;
    end else if (s1_fire) begin
      linked_q   <= linked_d;
      hop_q      <= hop_d;
      code_q     <= code_d;
      deadline_q <= deadline_d;
      groups_q   <= groups_d;
      missed_q   <= missed_d;
      rssi_q     <= rssi_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.status        = res_q.status;
  assign out_o.group         = res_q.group;
  assign out_o.chan_a        = res_q.chan_a;
  assign out_o.chan_b        = res_q.chan_b;
  assign out_o.chan_c        = res_q.chan_c;
  assign out_o.chan_d        = res_q.chan_d;
  assign out_o.radio_channel = res_q.radio_channel;
  assign out_o.retune        = res_q.retune;
  assign out_o.linked        = res_q.linked;
  assign out_o.rssi          = res_q.rssi;
  assign out_o.rssi_valid    = res_q.rssi_valid;

endmodule

`default_nettype wire

>>> rtl/hlr_checker.sv
`default_nettype none

module hlr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        status_i,
  input logic        group_i,
  input logic [47:0] chans_i,
  input logic        retune_i,
  input logic        linked_i,
  input logic        rssi_valid_i
);

  // A stalled item holds its data
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(chans_i) && $stable(status_i))
    else $error("stalled item changed");

  // Channel data only comes out while synchronized
  a_data_linked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> linked_i && rssi_valid_i)
    else $error("channel data without link");

  // No data means zero group and values
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !status_i |-> !group_i && (chans_i == '0))
    else $error("nonzero channel fields without data");

  // Hops happen only on polls without a frame
  a_hop_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && retune_i |-> !rssi_valid_i && !status_i)
    else $error("hop on a frame poll");

endmodule

bind hopping_link_receiver hlr_checker u_hlr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .status_i     (out_o.status),
  .group_i      (out_o.group),
  .chans_i      ({out_o.chan_a, out_o.chan_b, out_o.chan_c, out_o.chan_d}),
  .retune_i     (out_o.retune),
  .linked_i     (out_o.linked),
  .rssi_valid_i (out_o.rssi_valid)
);

`default_nettype wire
